// ===== design/tce_pkg.sv =====
`timescale 1ns / 1ps
package tce_pkg;
  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STEP_DEF = 4;
  localparam logic [7:0] ATTR_RESET = 8'h07;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;
    logic [11:0] addr;
    logic        keep_attr;
    logic        in_range;
    logic        scroll;
    logic [10:0] cursor;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_RMW,
    ST_SCRL_RD,
    ST_SCRL_WR,
    ST_BLANK,
    ST_CLEAR,
    ST_DONE
  } back_state_t;
endpackage

// ===== design/tce_front.sv =====
`timescale 1ns / 1ps
module tce_front #(
  parameter int COLUMNS  = tce_pkg::COLUMNS_DEF,
  parameter int ROWS     = tce_pkg::ROWS_DEF,
  parameter int TAB_STEP = tce_pkg::TAB_STEP_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    command,
  input  logic [7:0]    char_code,
  input  logic [6:0]    column,
  input  logic [4:0]    row,
  output logic          job_valid,
  input  logic          job_ready,
  output tce_pkg::job_t job
);
  import tce_pkg::*;

  localparam int CW = $clog2(COLUMNS + TAB_STEP + 1);

  logic [6:0] cursor_col;
  logic [4:0] cursor_row;
  logic [6:0] col_next;
  logic [4:0] row_next;
  logic [CW-1:0] ccol;
  logic [5:0] crow;
  logic [11:0] cur_idx;
  job_t j;

  assign in_ready = job_ready;
  assign job_valid = in_valid;
  assign job = j;
  assign cur_idx = 12'(cursor_row) * 12'(COLUMNS) + 12'(cursor_col);

  always_comb begin
    j = '0;
    j.op = OP_NONE;
    ccol = CW'(cursor_col);
    crow = 6'(cursor_row);
    j.addr = cur_idx;
    j.in_range = 1'b1;
    col_next = cursor_col;
    row_next = cursor_row;
    case (cmd_t'(command))
      CMD_PUT: begin
        if (char_code == CH_BACKSPACE) begin
          if (cursor_col != 7'd0) begin
            ccol = CW'(cursor_col - 7'd1);
            j.addr = cur_idx - 12'd1;
            j.op = OP_WRITE;
            j.keep_attr = 1'b1;
          end
        end else if (char_code == CH_NEWLINE) begin
          crow = crow + 6'd1;
          ccol = '0;
        end else if (char_code == CH_TAB) begin
          ccol = ccol + CW'(TAB_STEP);
        end else begin
          j.op = OP_WRITE;
          j.data = char_code;
          ccol = ccol + CW'(1);
        end
        // column carry: a tab step can pass at most two row widths
        if (32'(ccol) >= 2 * COLUMNS) begin
          ccol = ccol - CW'(2 * COLUMNS);
          crow = crow + 6'd2;
        end else if (32'(ccol) >= COLUMNS) begin
          ccol = ccol - CW'(COLUMNS);
          crow = crow + 6'd1;
        end
        if (crow > 6'(ROWS - 1)) crow = 6'(ROWS - 1);
        if (crow >= 6'(ROWS - 1)) begin
          j.scroll = 1'b1;
          crow = crow - 6'd1;
        end
        col_next = 7'(ccol);
        row_next = 5'(crow);
      end
      CMD_CLEAR: begin
        j.op = OP_CLEAR;
        col_next = '0;
        row_next = '0;
      end
      CMD_WRITE: begin
        j.op = OP_WRITE;
        j.data = char_code;
        j.in_range = (32'(column) < COLUMNS) && (32'(row) < ROWS);
        j.addr = 12'(row) * 12'(COLUMNS) + 12'(column);
      end
      default: begin
        j.op = OP_READ;
        j.in_range = (32'(column) < COLUMNS) && (32'(row) < ROWS);
        j.addr = 12'(row) * 12'(COLUMNS) + 12'(column);
      end
    endcase
    if (!j.in_range) j.op = (cmd_t'(command) == CMD_READ) ? OP_READ : OP_NONE;
    j.cursor = 11'(12'(row_next) * 12'(COLUMNS) + 12'(col_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (in_valid && in_ready) begin
      cursor_col <= col_next;
      cursor_row <= row_next;
    end
  end
endmodule

// ===== design/tce_queue.sv =====
`timescale 1ns / 1ps
module tce_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  tce_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output tce_pkg::job_t rd_data
);
  import tce_pkg::*;

  job_t slot [2];
  logic [1:0] count;
  logic wptr;
  logic rptr;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data = slot[rptr];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) slot[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (wr_valid && wr_ready) wptr <= ~wptr;
      if (rd_valid && rd_ready) rptr <= ~rptr;
      count <= count + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule

// ===== design/tce_back.sv =====
`timescale 1ns / 1ps
module tce_back #(
  parameter int COLUMNS = tce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tce_pkg::ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    attr,
  input  logic          job_valid,
  output logic          job_ready,
  input  tce_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [10:0]   cursor_position,
  output logic [7:0]    cell_char,
  output logic [7:0]    cell_attr,
  output logic          scrolled
);
  import tce_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW = $clog2(CELLS);
  localparam int SCROLL_END = (ROWS - 2) * COLUMNS;

  logic [15:0] mem [CELLS];
  logic [15:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic rd_en;
  logic        we;
  logic [AW-1:0] wa;
  logic [15:0] wd;

  back_state_t state;
  back_state_t state_next;
  job_t cur;
  logic [AW:0] ptr;
  logic [AW:0] ptr_next;
  logic init_pass;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  assign job_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ptr_next = ptr;
    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          ptr_next = '0;
          if (job.op == OP_CLEAR) state_next = ST_CLEAR;
          else if (job.op == OP_READ) state_next = job.in_range ? ST_RD : ST_DONE;
          else if (job.op == OP_WRITE && job.keep_attr) state_next = ST_RD;
          else if (job.op == OP_WRITE) state_next = ST_RMW;
          else if (job.scroll) state_next = ST_SCRL_RD;
          else state_next = ST_DONE;
        end
      end
      ST_RD: state_next = (cur.op == OP_READ) ? ST_DONE : ST_RMW;
      ST_RMW: state_next = cur.scroll ? ST_SCRL_RD : ST_DONE;
      ST_SCRL_RD: begin
        if (ptr >= (AW + 1)'(SCROLL_END)) begin
          state_next = ST_BLANK;
          ptr_next = (AW + 1)'(SCROLL_END);
        end else state_next = ST_SCRL_WR;
      end
      ST_SCRL_WR: begin
        state_next = ST_SCRL_RD;
        ptr_next = ptr + 1'b1;
      end
      ST_BLANK: begin
        ptr_next = ptr + 1'b1;
        if (ptr == (AW + 1)'(SCROLL_END + COLUMNS - 1)) state_next = ST_DONE;
      end
      ST_CLEAR: begin
        ptr_next = ptr + 1'b1;
        if (ptr == (AW + 1)'(CELLS - 1)) state_next = init_pass ? ST_IDLE : ST_DONE;
      end
      ST_DONE: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = cur.addr[AW-1:0];
    wd = {attr, cur.data};
    rd_en = 1'b0;
    rd_addr = job.addr[AW-1:0];
    case (state)
      ST_IDLE: rd_en = job_valid;
      ST_RMW: begin
        we = 1'b1;
        if (cur.keep_attr) wd = {rd_q[15:8], 8'd0};
      end
      ST_SCRL_RD: begin
        rd_en = 1'b1;
        rd_addr = AW'(ptr + (AW + 1)'(COLUMNS));
      end
      ST_SCRL_WR: begin
        we = 1'b1;
        wa = ptr[AW-1:0];
        wd = rd_q;
      end
      ST_BLANK: begin
        we = 1'b1;
        wa = ptr[AW-1:0];
        wd = {attr, 8'd0};
      end
      ST_CLEAR: begin
        we = 1'b1;
        wa = ptr[AW-1:0];
        // zero fill after reset, blank cells otherwise
        wd = init_pass ? 16'h0000 : {attr, 8'd0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      ptr <= '0;
      init_pass <= 1'b1;
    end else begin
      state <= state_next;
      ptr <= ptr_next;
      if (state == ST_CLEAR && ptr == (AW + 1)'(CELLS - 1)) init_pass <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && job_valid) cur <= job;
  end

  assign out_valid = (state == ST_DONE);
  assign cursor_position = cur.cursor;
  assign scrolled = cur.scroll;
  assign cell_char = (cur.op == OP_READ && cur.in_range) ? rd_q[7:0] : 8'd0;
  assign cell_attr = (cur.op == OP_READ && cur.in_range) ? rd_q[15:8] : 8'd0;
endmodule

// ===== design/text_console_engine_top.sv =====
`timescale 1ns / 1ps
// Text console: a ROWS x COLUMNS grid of 16-bit cells (attribute high byte,
// character low byte) in a single-port-write block memory, plus a cursor.
// The front stage updates the cursor and classifies each command in its
// accept cycle, and a two-entry queue feeds the back stage that does the
// memory work. The back stage takes one job at a time from the queue in its
// idle state. Character writes and direct cell writes go through a write
// state, reads through a read state, backspace through a read and a write
// state, tab and newline straight to the result. A scroll then copies the
// rows up through one memory port and blanks row ROWS-2; clear_screen writes
// every cell. After reset the back stage zero-fills the memory before it
// takes its first job; the queue still accepts two transactions meanwhile.
module text_console_engine_top #(
  parameter int COLUMNS  = tce_pkg::COLUMNS_DEF,
  parameter int ROWS     = tce_pkg::ROWS_DEF,
  parameter int TAB_STEP = tce_pkg::TAB_STEP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  char_code,
  input  logic [6:0]  column,
  input  logic [4:0]  row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] cursor_position,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_attr,
  output logic        scrolled
);
  import tce_pkg::*;

  logic [7:0] text_attribute;
  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;

  always_ff @(posedge clk) begin
    if (rst) text_attribute <= ATTR_RESET;
    else if (cfg_we) text_attribute <= cfg_wdata;
  end

  tce_front #(.COLUMNS(COLUMNS), .ROWS(ROWS), .TAB_STEP(TAB_STEP)) u_front (
    .clk, .rst, .in_valid, .in_ready, .command, .char_code, .column, .row,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  tce_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
  );

  tce_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk, .rst, .attr(text_attribute), .job_valid(b_valid), .job_ready(b_ready),
    .job(b_job), .out_valid, .out_ready, .cursor_position, .cell_char,
    .cell_attr, .scrolled
  );
endmodule

// ===== design/tce_checker.sv =====
`timescale 1ns / 1ps
module tce_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] cursor_position,
  input logic [7:0]  cell_char,
  input logic [7:0]  cell_attr
);
  import tce_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({cursor_position, cell_char, cell_attr}))
    else $error("result dropped while stalled");
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result right after reset");
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cursor_position < 11'(COLUMNS_DEF * ROWS_DEF))
    else $error("cursor off screen");
endmodule

bind text_console_engine_top tce_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .cursor_position, .cell_char, .cell_attr
);

// ===== bench/console_checker.sv =====
`timescale 1ns / 1ps
module console_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  char_code,
  input  logic [6:0]  column,
  input  logic [4:0]  row,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [10:0] cursor_position,
  input  logic [7:0]  cell_char,
  input  logic [7:0]  cell_attr,
  input  logic        scrolled,
  output int          fail_count,
  output int          pending
);
  import tce_pkg::*;

  localparam int COLS = COLUMNS_DEF;
  localparam int ROWN = ROWS_DEF;
  localparam int NCELLS = COLS * ROWN;

  typedef struct packed {
    logic [10:0] cursor;
    logic [7:0]  chr;
    logic [7:0]  attr;
    logic        scr;
  } console_result_t;

  logic [15:0] screen [NCELLS];
  int cur_col;
  int cur_row;
  logic [7:0] attr_reg;
  console_result_t expected_results[$];

  function automatic console_result_t apply_command(logic [1:0] cmd, logic [7:0] ch,
                                                   logic [6:0] col, logic [4:0] rw);
    console_result_t r;
    int idx;
    r = '0;
    case (cmd_t'(cmd))
      CMD_PUT: begin
        if (ch == CH_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            idx = cur_row * COLS + cur_col;
            if (idx < NCELLS) screen[idx] = {screen[idx][15:8], 8'h00};
          end
        end else if (ch == CH_NEWLINE) begin
          cur_row++;
          cur_col = 0;
        end else if (ch == CH_TAB) begin
          cur_col += TAB_STEP_DEF;
        end else begin
          idx = cur_row * COLS + cur_col;
          if (idx < NCELLS) screen[idx] = {attr_reg, ch};
          cur_col++;
        end
        if (cur_col >= COLS) begin
          cur_row += cur_col / COLS;
          cur_col = cur_col % COLS;
        end
        if (cur_row > ROWN - 1) cur_row = ROWN - 1;
        if (cur_row >= ROWN - 1) begin
          for (int i = 0; i < (ROWN - 2) * COLS; i++) screen[i] = screen[i + COLS];
          for (int i = (ROWN - 2) * COLS; i < (ROWN - 1) * COLS; i++)
            screen[i] = {attr_reg, 8'h00};
          cur_row--;
          r.scr = 1'b1;
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NCELLS; i++) screen[i] = {attr_reg, 8'h00};
        cur_col = 0;
        cur_row = 0;
      end
      CMD_WRITE: begin
        if (col < COLS && rw < ROWN) screen[rw * COLS + col] = {attr_reg, ch};
      end
      default: begin
        if (col < COLS && rw < ROWN) begin
          r.chr = screen[rw * COLS + col][7:0];
          r.attr = screen[rw * COLS + col][15:8];
        end
      end
    endcase
    r.cursor = 11'(cur_row * COLS + cur_col);
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    console_result_t exp_r;
    if (rst) begin
      for (int i = 0; i < NCELLS; i++) screen[i] = '0;
      cur_col = 0;
      cur_row = 0;
      attr_reg = ATTR_RESET;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result transaction: cursor %0d char %0d attr %0d scr %0d",
                     cursor_position, cell_char, cell_attr, scrolled);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.cursor !== cursor_position || exp_r.chr !== cell_char ||
              exp_r.attr !== cell_attr || exp_r.scr !== scrolled) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp cursor %0d char %0d attr %0d scr %0d, got %0d %0d %0d %0d",
                       exp_r.cursor, exp_r.chr, exp_r.attr, exp_r.scr,
                       cursor_position, cell_char, cell_attr, scrolled);
          end
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(apply_command(command, char_code, column, row));
      if (cfg_we) attr_reg = cfg_wdata;
    end
  end
endmodule

// ===== bench/tb_text_console_engine_top.sv =====
`timescale 1ns / 1ps
module tb_text_console_engine_top;
  import tce_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [7:0]  char_code;
  logic [6:0]  column;
  logic [4:0]  row;
  logic        out_valid;
  logic        out_ready;
  logic [10:0] cursor_position;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;
  logic        scrolled;
  int          fail_count;
  int          pending;
  int          cycles = 0;

  text_console_engine_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .char_code(char_code), .column(column), .row(row),
    .out_valid(out_valid), .out_ready(out_ready),
    .cursor_position(cursor_position), .cell_char(cell_char),
    .cell_attr(cell_attr), .scrolled(scrolled)
  );

  console_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .char_code(char_code), .column(column), .row(row),
    .out_valid(out_valid), .out_ready(out_ready),
    .cursor_position(cursor_position), .cell_char(cell_char),
    .cell_attr(cell_attr), .scrolled(scrolled),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst) begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        if ($urandom_range(0, 4) == 0) out_ready = 1'b0;
        repeat (idle_gap()) @(negedge clk);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_command(cmd_t cmd, logic [7:0] ch, logic [6:0] col, logic [4:0] rw);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    command = cmd;
    char_code = ch;
    column = col;
    row = rw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_attribute(logic [7:0] value);
    in_valid = 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_command();
    int c;
    int k;
    logic [7:0] ch;
    logic [6:0] col;
    logic [4:0] rw;
    c = $urandom_range(0, 99);
    ch = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) begin
      col = 7'($urandom_range(0, 127));
      rw = 5'($urandom_range(0, 31));
    end else begin
      col = 7'($urandom_range(0, COLUMNS_DEF - 1));
      rw = 5'($urandom_range(0, ROWS_DEF - 1));
    end
    if (c < 55) begin
      k = $urandom_range(0, 99);
      if (k < 8) ch = CH_BACKSPACE;
      else if (k < 12) ch = CH_NEWLINE;
      else if (k < 18) ch = CH_TAB;
      send_command(CMD_PUT, ch, col, rw);
    end else if (c < 58) begin
      send_command(CMD_CLEAR, ch, col, rw);
    end else if (c < 78) begin
      send_command(CMD_WRITE, ch, col, rw);
    end else begin
      send_command(CMD_READ, ch, col, rw);
    end
  endtask

  initial begin
    logic [7:0] attrs [5];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    command = '0;
    char_code = '0;
    column = '0;
    row = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // cells read as zero straight after reset
    send_command(CMD_READ, 8'h00, 7'd5, 5'd3);
    send_command(CMD_PUT, 8'h41, 7'd0, 5'd0);
    send_command(CMD_READ, 8'h00, 7'd0, 5'd0);
    send_command(CMD_CLEAR, 8'h00, 7'd0, 5'd0);
    send_command(CMD_PUT, CH_BACKSPACE, 7'd0, 5'd0);
    send_command(CMD_PUT, 8'h41, 7'd0, 5'd0);
    send_command(CMD_PUT, 8'hFF, 7'd0, 5'd0);
    send_command(CMD_PUT, 8'h00, 7'd0, 5'd0);
    send_command(CMD_PUT, CH_BACKSPACE, 7'd0, 5'd0);
    send_command(CMD_PUT, CH_TAB, 7'd0, 5'd0);
    send_command(CMD_PUT, CH_NEWLINE, 7'd0, 5'd0);
    send_command(CMD_WRITE, 8'hFF, 7'd0, 5'd0);
    send_command(CMD_WRITE, 8'h5A, 7'd79, 5'd24);
    send_command(CMD_WRITE, 8'h11, 7'd80, 5'd3);
    send_command(CMD_WRITE, 8'h22, 7'd3, 5'd25);
    send_command(CMD_WRITE, 8'h33, 7'd127, 5'd31);
    send_command(CMD_READ, 8'h00, 7'd0, 5'd0);
    send_command(CMD_READ, 8'hFF, 7'd79, 5'd24);
    send_command(CMD_READ, 8'h00, 7'd1, 5'd0);
    send_command(CMD_READ, 8'h00, 7'd80, 5'd0);
    send_command(CMD_READ, 8'h00, 7'd0, 5'd25);
    send_command(CMD_READ, 8'h00, 7'd127, 5'd31);
    for (int i = 0; i < 20; i++) send_command(CMD_PUT, CH_TAB, 7'd0, 5'd0);
    send_command(CMD_READ, 8'h00, 7'd2, 5'd1);

    attrs[0] = 8'hFF;
    attrs[1] = 8'h00;
    attrs[2] = 8'hA5;
    attrs[3] = 8'($urandom_range(0, 255));
    attrs[4] = 8'h5A;
    for (int p = 0; p < 5; p++) begin
      set_attribute(attrs[p]);
      for (int n = 0; n < 180; n++) random_command();
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/tce_pkg.sv
design/tce_front.sv
design/tce_queue.sv
design/tce_back.sv
design/text_console_engine_top.sv
design/tce_checker.sv
bench/console_checker.sv
bench/tb_text_console_engine_top.sv
